### rtl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types, widths and tables for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int VALUE_W    = 16;
  localparam int CHAR_W     = 6;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 5;
  localparam int POS_W      = 3;
  localparam int MULT_W     = 17;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // Row k holds d * 10^k for d = 0 to 9.
  localparam logic [MULT_W-1:0] POW_MULT [NUM_DIGITS][10] = '{
    '{17'd0, 17'd1, 17'd2, 17'd3, 17'd4, 17'd5, 17'd6, 17'd7, 17'd8, 17'd9},
    '{17'd0, 17'd10, 17'd20, 17'd30, 17'd40, 17'd50, 17'd60, 17'd70, 17'd80,
      17'd90},
    '{17'd0, 17'd100, 17'd200, 17'd300, 17'd400, 17'd500, 17'd600, 17'd700,
      17'd800, 17'd900},
    '{17'd0, 17'd1000, 17'd2000, 17'd3000, 17'd4000, 17'd5000, 17'd6000,
      17'd7000, 17'd8000, 17'd9000},
    '{17'd0, 17'd10000, 17'd20000, 17'd30000, 17'd40000, 17'd50000,
      17'd60000, 17'd70000, 17'd80000, 17'd90000}
  };

  typedef enum logic {
    ST_IDLE,
    ST_CONVERT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
    logic last_pos;
  } status_t;

endpackage

### rtl/b2da_ctrl.sv
// ----------------------------------------------------------------------------
// b2da_ctrl
// Controller that loads an item and steps the datapath once per digit place.
// ----------------------------------------------------------------------------
module b2da_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  input  b2da_pkg::status_t status,
  output b2da_pkg::cmd_t    cmd
);

  b2da_pkg::state_t state;
  b2da_pkg::state_t state_next;
  logic             can_step;

  assign can_step = !status.out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= b2da_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      b2da_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = b2da_pkg::ST_CONVERT;
        end
      end
      b2da_pkg::ST_CONVERT: begin
        if (can_step && status.last_pos) begin
          state_next = b2da_pkg::ST_IDLE;
        end
      end
      default: state_next = b2da_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      b2da_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      b2da_pkg::ST_CONVERT: begin
        cmd.step = can_step;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### rtl/b2da_datapath.sv
// ----------------------------------------------------------------------------
// b2da_datapath
// Remainder register, digit extraction per decimal place and output register.
// ----------------------------------------------------------------------------
module b2da_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  b2da_pkg::cmd_t                  cmd,
  input  logic [b2da_pkg::VALUE_W-1:0]    value,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [b2da_pkg::CHAR_W-1:0]     digit_char,
  output logic                            last,
  output b2da_pkg::status_t               status
);

  logic [b2da_pkg::VALUE_W-1:0] rem;
  logic [b2da_pkg::POS_W-1:0]   pos;
  logic                         started;
  logic [b2da_pkg::DIGIT_W-1:0] digit;
  logic [b2da_pkg::MULT_W-1:0]  sub;
  logic [b2da_pkg::MULT_W-1:0]  rem_ext;
  logic                         emit;

  assign rem_ext = {1'b0, rem};

  always_comb begin
    digit = '0;
    for (int d = 1; d < 10; d++) begin
      if (rem_ext >= b2da_pkg::POW_MULT[pos][d]) begin
        digit = b2da_pkg::DIGIT_W'(d);
      end
    end
  end

  assign sub  = b2da_pkg::POW_MULT[pos][digit];
  assign emit = (digit != '0) || started || (pos == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem     <= value;
      pos     <= b2da_pkg::POS_W'(b2da_pkg::NUM_DIGITS - 1);
      started <= 1'b0;
    end else if (cmd.step) begin
      rem     <= b2da_pkg::VALUE_W'(rem_ext - sub);
      pos     <= pos - b2da_pkg::POS_W'(1);
      started <= started | emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.step && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && emit) begin
      digit_char <= b2da_pkg::ASCII_ZERO + {2'b00, digit};
      last       <= (pos == '0);
    end
  end

  assign status.out_valid = out_valid;
  assign status.last_pos  = (pos == '0);

endmodule

### rtl/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts an unsigned 16-bit value to ASCII decimal digits, most significant
// first, with leading zeros suppressed and a flag on the final digit.
// ----------------------------------------------------------------------------
//   Channel  Handshake             Payload
//   input    in_valid / in_ready   value[15:0]
//   output   out_valid / out_ready digit_char[5:0], last
//
// Each item is accepted in the idle state and then takes one step for each
// decimal place, from ten thousands down to units.
// Suppressed leading zeros still take their step.
// A step waits while the output register holds a digit that is not taken.
// Synchronous reset clears the controller and the output valid flag.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [b2da_pkg::VALUE_W-1:0]    value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [b2da_pkg::CHAR_W-1:0]     digit_char,
  output logic                            last
);

  b2da_pkg::cmd_t    cmd;
  b2da_pkg::status_t status;

  b2da_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  b2da_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .value      (value),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .digit_char (digit_char),
    .last       (last),
    .status     (status)
  );

  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready
  ) else $error("input ready stayed high after an item was accepted");

  a_digit_range: assert property (
    @(posedge clk) disable iff (rst)
    out_valid |-> digit_char >= b2da_pkg::ASCII_ZERO &&
                  digit_char <= b2da_pkg::ASCII_ZERO + 6'd9
  ) else $error("output character is not a decimal digit");

  a_last_on_finish: assert property (
    @(posedge clk) disable iff (rst)
    $past(!rst) && $rose(in_ready) |-> out_valid && last
  ) else $error("conversion finished without a final digit pending");

endmodule

### sim/b2da_checker.sv
// ----------------------------------------------------------------------------
// b2da_checker
// Watches both channels of the decimal ASCII converter. Each accepted value
// is expanded into its expected digit characters, and each digit that leaves
// the block is compared with the oldest expected one.
// ----------------------------------------------------------------------------
module b2da_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [b2da_pkg::VALUE_W-1:0]  value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [b2da_pkg::CHAR_W-1:0]   digit_char,
  input  logic                          last,
  output int                            errors,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [b2da_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } digit_t;

  digit_t digits_due[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic void queue_decimal_digits(input logic [b2da_pkg::VALUE_W-1:0] v);
    logic [b2da_pkg::DIGIT_W-1:0] rev [b2da_pkg::NUM_DIGITS];
    int unsigned                  rest;
    int                           n;
    digit_t                       d;
    rest = v;
    n = 0;
    if (rest == 0) begin
      rev[0] = '0;
      n = 1;
    end else begin
      while (rest > 0 && n < b2da_pkg::NUM_DIGITS) begin
        rev[n] = b2da_pkg::DIGIT_W'(rest % 10);
        rest = rest / 10;
        n++;
      end
    end
    for (int k = 0; k < n; k++) begin
      d.ch   = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(rev[n-1-k]);
      d.last = (k == n - 1);
      digits_due.push_back(d);
    end
  endfunction

  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    digit_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (digits_due.size() == 0) begin
          flag_error($sformatf("digit 0x%0h last %0b with no item pending",
                               digit_char, last));
        end else begin
          want = digits_due.pop_front();
          if (digit_char !== want.ch)
            flag_error($sformatf("digit_char 0x%0h, expected 0x%0h",
                                 digit_char, want.ch));
          if (last !== want.last)
            flag_error($sformatf("last %0b, expected %0b", last, want.last));
        end
      end
      if (in_valid && in_ready)
        queue_decimal_digits(value);
    end
    pending <= digits_due.size();
  end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives values into the decimal ASCII converter with bursty input and a
// stalling receiver, including a long receiver hold-off and a full drain,
// and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_LEN   = 300;
  localparam int RAND_ITEMS = 245;
  localparam int FILL_ITEMS = 40;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [b2da_pkg::VALUE_W-1:0] value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [b2da_pkg::CHAR_W-1:0]  digit_char;
  logic                         last;
  int                           errors;
  int                           pending;
  int                           idle_cycles = 0;
  logic                         hold_req = 1'b0;
  logic                         hold_done = 1'b0;

  binary_to_decimal_ascii u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last       (last)
  );

  b2da_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last       (last),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int mode_left;
    int stall_pct;
    mode_left = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 30;
            default: stall_pct = 75;
          endcase
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic logic [b2da_pkg::VALUE_W-1:0] pick_value();
    int unsigned lo;
    int unsigned hi;
    int unsigned p;
    int          n;
    case ($urandom_range(0, 4))
      0, 1: begin
        n = $urandom_range(1, b2da_pkg::NUM_DIGITS);
        lo = (n == 1) ? 0 : 10 ** (n - 1);
        hi = (n == b2da_pkg::NUM_DIGITS) ? 65535 : 10 ** n - 1;
        return b2da_pkg::VALUE_W'($urandom_range(hi, lo));
      end
      2: begin
        p = 10 ** $urandom_range(0, b2da_pkg::NUM_DIGITS - 1);
        return b2da_pkg::VALUE_W'(p + $urandom_range(0, 2) - 1);
      end
      default: return b2da_pkg::VALUE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic offer(input logic [b2da_pkg::VALUE_W-1:0] v);
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_bursts(input int count);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      if (burst > left)
        burst = left;
      repeat (burst) begin
        offer(pick_value());
        left--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        value    <= b2da_pkg::VALUE_W'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    logic [b2da_pkg::VALUE_W-1:0] directed [$];
    directed = {16'd0, 16'd1, 16'd9, 16'd10, 16'd11, 16'd99, 16'd100, 16'd101,
                16'd999, 16'd1000, 16'd1001, 16'd9999, 16'd10000, 16'd10001,
                16'd65535, 16'd65534, 16'd32768, 16'd50000, 16'd60000,
                16'd12345, 16'd54321, 16'hAAAA, 16'h5555, 16'd90, 16'd1024};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      offer(directed[i]);
      if ($urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
    drain();

    hold_req <= 1'b1;
    repeat (FILL_ITEMS) offer(pick_value());
    drain();

    send_bursts(RAND_ITEMS);
    drain();
    repeat (20) @(posedge clk);

    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

### filelist.f
rtl/b2da_pkg.sv
rtl/b2da_ctrl.sv
rtl/b2da_datapath.sv
rtl/binary_to_decimal_ascii.sv
sim/b2da_checker.sv
sim/tb_top.sv
